/* rtl/bfrl_pkg.sv */
// Shared types and constants for the run-length Brainfuck execution core.
package bfrl_pkg;

  // Default number of byte cells on the tape.
  localparam int TAPE_CELLS_DEF = 4096;

  // Field widths of the token and result channels.
  localparam int CMD_W  = 3;
  localparam int AMT_W  = 16;
  localparam int BYTE_W = 8;
  localparam int PC_W   = 16;

  // Head arithmetic is done one bit wider than the amount, which covers heads of up to AMT_W bits.
  localparam int SUM_W  = AMT_W + 1;

  // Token commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_RIGHT = 3'd0,
    CMD_LEFT  = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_SUB   = 3'd3,
    CMD_OUT   = 3'd4,
    CMD_IN    = 3'd5,
    CMD_OPEN  = 3'd6,
    CMD_CLOSE = 3'd7
  } cmd_t;

endpackage

/* rtl/bfrl_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module bfrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/brainfuck_run_length_core.sv */
// Top level of the run-length Brainfuck execution core.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------------
//   in      | in_valid  | in_stall  | in_command, in_amount, in_in_byte
//   out     | out_valid | out_stall | out_next_pc, out_out_valid, out_out_byte,
//           |           |           | out_out_repeat, out_tape_overflow
//
// One token is taken per cycle while in_stall is low. A token reads its tape cell in
// the cycle of its transfer, is finished and written back in the finishing stage, and
// its result is then registered in the output register. The tape memory's single read
// and write ports set this rate; a write that hits the cell the next token reads is
// forwarded. After reset the tape is zeroed by a clearing pass, one cell a cycle,
// during which in_stall is high. A stalled result holds the finishing stage, which in
// turn raises in_stall.
module brainfuck_run_length_core #(
  parameter int TAPE_CELLS = bfrl_pkg::TAPE_CELLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bfrl_pkg::CMD_W-1:0]  in_command,
  input  logic [bfrl_pkg::AMT_W-1:0]  in_amount,
  input  logic [bfrl_pkg::BYTE_W-1:0] in_in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bfrl_pkg::PC_W-1:0]   out_next_pc,
  output logic                        out_out_valid,
  output logic [bfrl_pkg::BYTE_W-1:0] out_out_byte,
  output logic [bfrl_pkg::AMT_W-1:0]  out_out_repeat,
  output logic                        out_tape_overflow
);
  import bfrl_pkg::*;

  localparam int ADDR_W = $clog2(TAPE_CELLS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(TAPE_CELLS - 1);

  // Control state.
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic              s1_valid_r;
  logic              fwd_hit_r;
  logic              out_valid_r;

  // Payload of the finishing stage, forwarding and output registers.
  cmd_t              s1_cmd_r;
  logic [AMT_W-1:0]  s1_amt_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_ovf_r;
  logic [BYTE_W-1:0] fwd_data_r;
  logic [PC_W-1:0]   out_pc_r;
  logic              out_flag_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [AMT_W-1:0]  out_rep_r;
  logic              out_ovf_r;

  logic              in_xfer;
  logic              s1_go;
  logic              s1_done;
  cmd_t              in_cmd;
  logic [SUM_W-1:0]  head_ext;
  logic [SUM_W-1:0]  amt_ext;
  logic [SUM_W-1:0]  right_sum;
  logic              right_ovf;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] cell_val;
  logic [BYTE_W-1:0] cell_wdata;
  logic              cell_we;
  logic [PC_W-1:0]   step_pc;
  logic [PC_W-1:0]   jump_pc;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;

  // Handshake: the finishing stage moves on when the output register is free or drained.
  assign s1_go    = !out_valid_r || !out_stall;
  assign s1_done  = s1_valid_r && s1_go;
  assign in_stall = clr_busy_r || (s1_valid_r && !s1_go);
  assign in_xfer  = in_valid && !in_stall;
  assign in_cmd   = cmd_t'(in_command);

  // Head update happens at transfer time; it needs only the head and the amount.
  assign head_ext  = SUM_W'(head_r);
  assign amt_ext   = SUM_W'(in_amount);
  assign right_sum = head_ext + amt_ext;
  assign right_ovf = right_sum > SUM_W'(TAPE_CELLS - 1);

  always_comb begin
    head_nxt = head_r;
    if (in_xfer) begin
      if (in_cmd == CMD_RIGHT) begin
        head_nxt = right_ovf ? LAST_CELL : right_sum[ADDR_W-1:0];
      end else if (in_cmd == CMD_LEFT) begin
        head_nxt = (amt_ext > head_ext) ? '0 : ADDR_W'(head_ext - amt_ext);
      end
    end
  end

  // Tape memory: the clearing pass owns the write port until it finishes.
  assign ram_we    = clr_busy_r || cell_we;
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clr_busy_r ? '0 : cell_wdata;

  bfrl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Finishing stage: take the forwarded cell if the previous token wrote it.
  assign cell_val = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign step_pc  = pc_r + PC_W'(1);
  assign jump_pc  = s1_amt_r + PC_W'(1);

  always_comb begin
    cell_wdata = cell_val;
    cell_we    = 1'b0;
    pc_nxt     = step_pc;
    unique case (s1_cmd_r)
      CMD_ADD: begin
        cell_wdata = cell_val + s1_amt_r[BYTE_W-1:0];
        cell_we    = s1_done;
      end
      CMD_SUB: begin
        cell_wdata = cell_val - s1_amt_r[BYTE_W-1:0];
        cell_we    = s1_done;
      end
      CMD_IN: begin
        cell_wdata = s1_byte_r;
        cell_we    = s1_done && (s1_amt_r != '0);
      end
      CMD_OPEN: begin
        if (cell_val == '0) begin
          pc_nxt = jump_pc;
        end
      end
      CMD_CLOSE: begin
        if (cell_val != '0) begin
          pc_nxt = jump_pc;
        end
      end
      CMD_RIGHT, CMD_LEFT, CMD_OUT: begin
        cell_we = 1'b0;
      end
      default: begin
        cell_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      head_r      <= '0;
      pc_r        <= '0;
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_CELL) begin
          clr_busy_r <= 1'b0;
        end
      end
      head_r <= head_nxt;
      if (s1_done) begin
        pc_r <= pc_nxt;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= cell_we && (s1_addr_r == head_r);
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r   <= in_cmd;
      s1_amt_r   <= in_amount;
      s1_byte_r  <= in_in_byte;
      s1_addr_r  <= head_r;
      s1_ovf_r   <= (in_cmd == CMD_RIGHT) && right_ovf;
      fwd_data_r <= cell_wdata;
    end
    if (s1_done) begin
      out_pc_r   <= pc_nxt;
      out_flag_r <= (s1_cmd_r == CMD_OUT);
      out_byte_r <= (s1_cmd_r == CMD_OUT) ? cell_val : '0;
      out_rep_r  <= (s1_cmd_r == CMD_OUT) ? s1_amt_r : '0;
      out_ovf_r  <= s1_ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_pc       = out_pc_r;
  assign out_out_valid     = out_flag_r;
  assign out_out_byte      = out_byte_r;
  assign out_out_repeat    = out_rep_r;
  assign out_tape_overflow = out_ovf_r;

endmodule
